// ===== design/cmf_pkg.sv =====
// shared types, constants and helper functions for the capacitance meter
// no dependencies; used by cmf_div, the top level and the testbench
package cmf_pkg;

    // fixed widths of the datapath and ports
    localparam int DIV_W      = 64;
    localparam int CAP_W      = 26;
    localparam int FREQ_OUT_W = 28;
    localparam int UNIT_W     = 2;
    localparam int GATE_W     = 12;
    localparam int MULT_W     = 24;

    // gate times in milliseconds
    localparam logic [GATE_W-1:0] GATE_RESET = 12'd100;
    localparam logic [GATE_W-1:0] GATE_SLOW  = 12'd3000;
    localparam logic [GATE_W-1:0] GATE_MID   = 12'd500;
    localparam logic [GATE_W-1:0] GATE_FAST  = 12'd300;

    // frequency limits for the gate choice, in hertz
    localparam logic [DIV_W-1:0] FREQ_SLOW_LIMIT = 64'd5;
    localparam logic [DIV_W-1:0] FREQ_MID_LIMIT  = 64'd30;

    // autorange bounds in Q10.16: 0.8 and 800
    localparam logic [DIV_W-1:0] LOW_BOUND  = 64'd52428;
    localparam logic [DIV_W-1:0] HIGH_BOUND = 64'd52428800;

    // saturation limits
    localparam logic [DIV_W-1:0] FREQ_MAX = 64'h0FFF_FFFF;
    localparam logic [DIV_W-1:0] CAP_MAX  = 64'h03FF_FFFF;

    // register reset value, about 295.32 in Q10.16
    localparam logic [CAP_W-1:0] CAP_RESET = 26'd19354091;

    // unit prefix codes
    localparam logic [UNIT_W-1:0] UNIT_PICO  = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_NANO  = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_MICRO = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLOAD,
        ST_FDIV,
        ST_CLOAD,
        ST_CDIV,
        ST_EMIT
    } state_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // prefix scale applied to the micro value
    function automatic logic [MULT_W-1:0] unit_mult(input logic [UNIT_W-1:0] unit);
        logic [MULT_W-1:0] m;
        unique case (unit)
            UNIT_PICO: m = 24'd1000000;
            UNIT_NANO: m = 24'd1000;
            default:   m = 24'd1;
        endcase
        return m;
    endfunction

endpackage

// ===== design/cmf_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on cmf_pkg for the datapath width and the status struct
module cmf_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cmf_pkg::DIV_W-1:0] num,
    input  logic [cmf_pkg::DIV_W-1:0] den,
    output logic [cmf_pkg::DIV_W-1:0] quo,
    output cmf_pkg::div_stat_t        stat
);

    localparam int W     = cmf_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W:0]       shifted;
    logic             ge;

    // one shift, compare and subtract step
    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        ge        = shifted >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = num;
            rem_next = '0;
            cnt_next = CNT_W'(W);
        end else if (cnt_reg != '0) begin
            quo_next  = {quo_reg[W-2:0], ge};
            rem_next  = ge ? W'(shifted - {1'b0, den_reg}) : shifted[W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // operand registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = (cnt_reg != '0) || done_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/cmf_ring.sv =====
// frequency history ring with a running sum of all entries
// no dependencies; the width and depth come in as parameters
module cmf_ring #(
    parameter int AVG_DEPTH = 3,
    parameter int ENTRY_W   = 42,
    parameter int SUM_W     = 44
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [ENTRY_W-1:0] wr_data,
    output logic [SUM_W-1:0]   sum
);

    localparam int POS_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

    logic [ENTRY_W-1:0] ring_reg [AVG_DEPTH];
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    // next position and sum with the oldest entry replaced
    always_comb begin
        pos_next = (pos_reg == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        sum_next = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(wr_data);
    end

    // ring entries, position and sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            pos_reg <= '0;
            sum_reg <= '0;
        end else if (wr_en) begin
            ring_reg[pos_reg] <= wr_data;
            pos_reg           <= pos_next;
            sum_reg           <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== design/capacitance_meter_from_frequency.sv =====
// top level of the capacitance meter: sequencer, gate and unit state, output register
// depends on cmf_pkg, cmf_div and cmf_ring
//
// Each input beat carries the oscillator edge count of one gate window. The block
// turns it into a frequency (count * 1000 / gate time), picks the gate time for the
// next window, averages the last AVG_DEPTH frequencies and gives the capacitance
// cap_constant / average in Q10.16, autoranged into (0.8, 800] across pico, nano and
// micro. Windows below 1 Hz give no result and leave all state untouched. All
// arithmetic runs through one 64-step restoring divider: one division for the
// frequency and one to four for the capacitance (the autorange may step down twice
// and back up once), each started from its own load state. An item that gives no
// result ends after its frequency division; the others go on through the
// capacitance divisions and wait while a full output register is not taken.
// The input is not ready while an item is in work; a finished result waits in the
// output register while the next beat is taken. cfg_ready is always high; write the
// register only while the block is idle, since a write takes effect at once.
module capacitance_meter_from_frequency #(
    parameter int AVG_DEPTH  = 3,
    parameter int COUNT_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cmf_pkg::CAP_W-1:0]      cfg_data,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [COUNT_BITS-1:0]          s_edge_count,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cmf_pkg::FREQ_OUT_W-1:0] m_freq_hz,
    output logic [cmf_pkg::CAP_W-1:0]      m_cap_value,
    output logic [cmf_pkg::UNIT_W-1:0]     m_unit_code,
    output logic [cmf_pkg::GATE_W-1:0]     m_next_gate_ms
);

    localparam int DW       = cmf_pkg::DIV_W;
    localparam int SCALED_W = COUNT_BITS + 10;
    localparam int ENTRY_W  = SCALED_W + 8;
    localparam int SUM_W    = ENTRY_W + $clog2(AVG_DEPTH + 1);
    localparam int PROD_W   = cmf_pkg::CAP_W + cmf_pkg::MULT_W;

    cmf_pkg::state_t    state_reg, state_next;
    cmf_pkg::div_stat_t div_stat;

    logic [cmf_pkg::CAP_W-1:0]      cap_const_reg;
    logic [cmf_pkg::GATE_W-1:0]     gate_reg;
    logic [cmf_pkg::UNIT_W-1:0]     unit_state_reg;
    logic [cmf_pkg::UNIT_W-1:0]     u_reg;
    logic                           up_reg;
    logic [SCALED_W-1:0]            scaled_reg;
    logic [cmf_pkg::FREQ_OUT_W-1:0] freq_reg;
    logic [cmf_pkg::CAP_W-1:0]      capv_reg;
    logic                           m_valid_reg;
    logic [cmf_pkg::FREQ_OUT_W-1:0] m_freq_reg;
    logic [cmf_pkg::CAP_W-1:0]      m_cap_reg;
    logic [cmf_pkg::UNIT_W-1:0]     m_unit_reg;
    logic [cmf_pkg::GATE_W-1:0]     m_gate_reg;

    logic [DW-1:0]                  div_num, div_den, div_quo;
    logic                           div_start;
    logic [DW-9:0]                  freq_full;
    logic [cmf_pkg::MULT_W-1:0]     kmul;
    logic [PROD_W-1:0]              cap_prod;
    logic [SUM_W-1:0]               ring_sum;
    logic                           ring_wr;
    logic                           s_fire, cfg_fire, out_free;
    logic                           freq_zero, go_down, go_up, emit_load;

    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign freq_full = div_quo[DW-1:8];
    assign freq_zero = (freq_full == '0);

    // autorange decisions on the divider result
    assign go_down = !up_reg && (div_quo <= cmf_pkg::LOW_BOUND) && (u_reg != cmf_pkg::UNIT_PICO);
    assign go_up   = !go_down && (div_quo > cmf_pkg::HIGH_BOUND) && (u_reg < cmf_pkg::UNIT_MICRO);

    // capacitance numerator: cap_constant * depth * prefix scale, Q.8 for the ring sum
    assign kmul     = cmf_pkg::MULT_W'(AVG_DEPTH) * cmf_pkg::unit_mult(u_reg);
    assign cap_prod = PROD_W'(cap_const_reg) * PROD_W'(kmul);

    // divider operand select
    always_comb begin
        if (state_reg == cmf_pkg::ST_FLOAD) begin
            div_num = DW'({scaled_reg, 8'b0});
            div_den = DW'(gate_reg);
        end else begin
            div_num = DW'({cap_prod, 8'b0});
            div_den = DW'(ring_sum);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cmf_pkg::ST_IDLE: begin
                if (s_fire) state_next = cmf_pkg::ST_FLOAD;
            end
            cmf_pkg::ST_FLOAD: state_next = cmf_pkg::ST_FDIV;
            cmf_pkg::ST_FDIV: begin
                if (div_stat.done) begin
                    state_next = freq_zero ? cmf_pkg::ST_IDLE : cmf_pkg::ST_CLOAD;
                end
            end
            cmf_pkg::ST_CLOAD: state_next = cmf_pkg::ST_CDIV;
            cmf_pkg::ST_CDIV: begin
                if (div_stat.done) begin
                    state_next = (go_down || go_up) ? cmf_pkg::ST_CLOAD : cmf_pkg::ST_EMIT;
                end
            end
            cmf_pkg::ST_EMIT: begin
                if (out_free) state_next = cmf_pkg::ST_IDLE;
            end
            default: state_next = cmf_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        ring_wr   = 1'b0;
        emit_load = 1'b0;
        unique case (state_reg)
            cmf_pkg::ST_IDLE:  s_ready   = 1'b1;
            cmf_pkg::ST_FLOAD: div_start = 1'b1;
            cmf_pkg::ST_FDIV:  ring_wr   = div_stat.done && !freq_zero;
            cmf_pkg::ST_CLOAD: div_start = 1'b1;
            cmf_pkg::ST_CDIV:  ;
            cmf_pkg::ST_EMIT:  emit_load = out_free;
            default:           ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cmf_pkg::ST_IDLE;
            cap_const_reg  <= cmf_pkg::CAP_RESET;
            gate_reg       <= cmf_pkg::GATE_RESET;
            unit_state_reg <= cmf_pkg::UNIT_MICRO;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                cap_const_reg <= cfg_data;
            end
            // next gate time from the new frequency
            if (ring_wr) begin
                if (freq_full < cmf_pkg::FREQ_SLOW_LIMIT[DW-9:0]) begin
                    gate_reg <= cmf_pkg::GATE_SLOW;
                end else if (freq_full < cmf_pkg::FREQ_MID_LIMIT[DW-9:0]) begin
                    gate_reg <= cmf_pkg::GATE_MID;
                end else begin
                    gate_reg <= cmf_pkg::GATE_FAST;
                end
            end
            if (emit_load) begin
                unit_state_reg <= u_reg;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working data
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            scaled_reg <= SCALED_W'(s_edge_count) * SCALED_W'(1000);
        end
        if (ring_wr) begin
            freq_reg <= (freq_full > cmf_pkg::FREQ_MAX[DW-9:0]) ?
                        cmf_pkg::FREQ_OUT_W'(cmf_pkg::FREQ_MAX) :
                        freq_full[cmf_pkg::FREQ_OUT_W-1:0];
            u_reg    <= unit_state_reg;
            up_reg   <= 1'b0;
        end
        if (state_reg == cmf_pkg::ST_CDIV && div_stat.done) begin
            if (go_down) begin
                u_reg <= u_reg - 1'b1;
            end else if (go_up) begin
                u_reg  <= u_reg + 1'b1;
                up_reg <= 1'b1;
            end else begin
                capv_reg <= (div_quo > cmf_pkg::CAP_MAX) ?
                            cmf_pkg::CAP_W'(cmf_pkg::CAP_MAX) :
                            div_quo[cmf_pkg::CAP_W-1:0];
            end
        end
        if (emit_load) begin
            m_freq_reg <= freq_reg;
            m_cap_reg  <= capv_reg;
            m_unit_reg <= u_reg;
            m_gate_reg <= gate_reg;
        end
    end

    cmf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .stat    (div_stat)
    );

    cmf_ring #(
        .AVG_DEPTH (AVG_DEPTH),
        .ENTRY_W   (ENTRY_W),
        .SUM_W     (SUM_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ring_wr),
        .wr_data (div_quo[ENTRY_W-1:0]),
        .sum     (ring_sum)
    );

    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_freq_hz      = m_freq_reg;
    assign m_cap_value    = m_cap_reg;
    assign m_unit_code    = m_unit_reg;
    assign m_next_gate_ms = m_gate_reg;

    // no new beat while the divider is still working
    a_ready_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("input ready while divider busy");

    // divider finishes only where the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == cmf_pkg::ST_FDIV || state_reg == cmf_pkg::ST_CDIV))
        else $error("divider done outside a wait state");

    // held prefix never leaves pico..micro
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_state_reg <= cmf_pkg::UNIT_MICRO)
        else $error("unit state out of range");

    // gate time is always one of the supported windows
    a_gate_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        gate_reg == cmf_pkg::GATE_RESET || gate_reg == cmf_pkg::GATE_SLOW ||
        gate_reg == cmf_pkg::GATE_MID || gate_reg == cmf_pkg::GATE_FAST)
        else $error("illegal gate time");

    // a fresh result beat carries a non-zero frequency and a chosen next gate
    a_result_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> m_valid && m_freq_hz != '0 && m_next_gate_ms != cmf_pkg::GATE_RESET)
        else $error("result beat with zero frequency or unchosen gate");

endmodule

// ===== test/capacitance_meter_from_frequency_test.sv =====
// self-checking testbench for capacitance_meter_from_frequency: directed and random edge counts,
// random idling on both channels, constant written between phases
// depends on cmf_pkg and the design files of the block
module capacitance_meter_from_frequency_test;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int COUNT_W        = 24;
    localparam int HIST_DEPTH     = 3;
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 40;
    localparam int PHASE_ITEMS    = 80;

    // gate times and frequency thresholds
    localparam logic [cmf_pkg::GATE_W-1:0] GATE_START_MS = 12'd100;
    localparam logic [cmf_pkg::GATE_W-1:0] GATE_SLOW_MS  = 12'd3000;
    localparam logic [cmf_pkg::GATE_W-1:0] GATE_MID_MS   = 12'd500;
    localparam logic [cmf_pkg::GATE_W-1:0] GATE_FAST_MS  = 12'd300;
    localparam logic [63:0] FREQ_SLOW_HZ = 64'd5;
    localparam logic [63:0] FREQ_MID_HZ  = 64'd30;

    // autorange window (0.8, 800] in Q10.16 and saturation limits
    localparam logic [63:0] RANGE_LOW_Q16  = 64'd52428;
    localparam logic [63:0] RANGE_HIGH_Q16 = 64'd52428800;
    localparam logic [63:0] FREQ_SAT       = 64'h0FFF_FFFF;
    localparam logic [63:0] CAP_SAT        = 64'h03FF_FFFF;

    localparam logic [cmf_pkg::CAP_W-1:0] OSC_CONST_DEFAULT = 26'd19354091;
    localparam logic [cmf_pkg::CAP_W-1:0] OSC_CONST_MAX     = 26'h3FF_FFFF;

    typedef enum logic [cmf_pkg::UNIT_W-1:0] {
        PREFIX_PICO,
        PREFIX_NANO,
        PREFIX_MICRO
    } prefix_t;

    typedef struct packed {
        logic [cmf_pkg::FREQ_OUT_W-1:0] freq_hz;
        logic [cmf_pkg::CAP_W-1:0]      cap_value;
        prefix_t                        unit;
        logic [cmf_pkg::GATE_W-1:0]     next_gate;
    } reading_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cmf_pkg::CAP_W-1:0]      cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [COUNT_W-1:0]             s_edge_count = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [cmf_pkg::FREQ_OUT_W-1:0] m_freq_hz;
    logic [cmf_pkg::CAP_W-1:0]      m_cap_value;
    logic [cmf_pkg::UNIT_W-1:0]     m_unit_code;
    logic [cmf_pkg::GATE_W-1:0]     m_next_gate_ms;

    // meter state as the block should hold it
    logic [cmf_pkg::CAP_W-1:0]  osc_constant = OSC_CONST_DEFAULT;
    logic [cmf_pkg::GATE_W-1:0] gate_ms = GATE_START_MS;
    logic [63:0]                freq_hist [HIST_DEPTH] = '{default: '0};
    int                         hist_pos = 0;
    prefix_t                    held_prefix = PREFIX_MICRO;

    logic [COUNT_W-1:0] pending_counts [$];
    reading_t           expected_readings [$];
    logic               fresh_valid = 1'b0;
    reading_t           fresh_reading = '0;
    int                 send_gap_pct = 0;
    int                 stall_pct = 0;
    int                 mismatches = 0;
    int                 idle_cycles = 0;

    capacitance_meter_from_frequency DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_edge_count   (s_edge_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_freq_hz      (m_freq_hz),
        .m_cap_value    (m_cap_value),
        .m_unit_code    (m_unit_code),
        .m_next_gate_ms (m_next_gate_ms)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // exact floor of num * prefix scale / den, split so nothing overflows
    function automatic logic [63:0] cap_at_prefix(input logic [63:0] num,
                                                  input logic [63:0] den, input prefix_t p);
        logic [63:0] mult;
        case (p)
            PREFIX_PICO: mult = 64'd1000000;
            PREFIX_NANO: mult = 64'd1000;
            default:     mult = 64'd1;
        endcase
        return (num / den) * mult + ((num % den) * mult) / den;
    endfunction

    // one gate window: frequency, next gate, running average, autoranged capacitance
    function automatic bit predict_reading(input logic [COUNT_W-1:0] count,
                                           output reading_t r);
        logic [63:0] scaled;
        logic [63:0] freq;
        logic [63:0] sum;
        logic [63:0] num;
        logic [63:0] v;
        logic [63:0] gate_now;
        prefix_t     p;
        r = '0;
        gate_now = 64'(gate_ms);
        scaled = 64'(count) * 64'd1000;
        freq = scaled / gate_now;
        // under one hertz nothing moves
        if (freq == 0)
            return 1'b0;
        if (freq < FREQ_SLOW_HZ)
            gate_ms = GATE_SLOW_MS;
        else if (freq < FREQ_MID_HZ)
            gate_ms = GATE_MID_MS;
        else
            gate_ms = GATE_FAST_MS;
        // history holds Q28.8 frequencies, empty slots count as zero
        freq_hist[hist_pos] = (scaled * 64'd256) / gate_now;
        hist_pos = (hist_pos + 1 >= HIST_DEPTH) ? 0 : hist_pos + 1;
        sum = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
            sum += freq_hist[i];
        num = 64'(osc_constant) * HIST_DEPTH * 64'd256;
        p = held_prefix;
        v = cap_at_prefix(num, sum, p);
        while (v <= RANGE_LOW_Q16 && p != PREFIX_PICO) begin
            p = prefix_t'(p - 1);
            v = cap_at_prefix(num, sum, p);
        end
        while (v > RANGE_HIGH_Q16 && p != PREFIX_MICRO) begin
            p = prefix_t'(p + 1);
            v = cap_at_prefix(num, sum, p);
        end
        held_prefix = p;
        r.freq_hz   = (freq > FREQ_SAT) ? FREQ_SAT[cmf_pkg::FREQ_OUT_W-1:0] :
                                          freq[cmf_pkg::FREQ_OUT_W-1:0];
        r.cap_value = (v > CAP_SAT) ? CAP_SAT[cmf_pkg::CAP_W-1:0] : v[cmf_pkg::CAP_W-1:0];
        r.unit      = p;
        r.next_gate = gate_ms;
        return 1'b1;
    endfunction

    // wide spread of magnitudes, a quarter of them full-width
    function automatic logic [COUNT_W-1:0] random_count();
        int w;
        w = $urandom_range(COUNT_W, 0);
        if ($urandom_range(3) == 0)
            return COUNT_W'($urandom);
        return COUNT_W'($urandom & ((32'd1 << w) - 1));
    endfunction

    // runs of near-equal counts so the average settles, mixed with lone values
    task automatic load_random(input int n);
        logic [COUNT_W-1:0] base;
        int run;
        while (n > 0) begin
            base = random_count();
            run = ($urandom_range(3) == 0) ? 1 : $urandom_range(8, 2);
            for (int i = 0; i < run && n > 0; i++) begin
                pending_counts.push_back(base + COUNT_W'($urandom_range(7)));
                n--;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // hold off until every beat is sent and every result is back, then let the block settle
    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_counts.size() != 0 || s_valid || fresh_valid ||
               expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_constant(input logic [cmf_pkg::CAP_W-1:0] k);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // predictor copy of the register
    always @(posedge aclk) begin
        if (!aresetn)
            osc_constant <= OSC_CONST_DEFAULT;
        else if (cfg_valid && cfg_ready)
            osc_constant <= cfg_data;
    end

    // driver: present queued counts, predict on each accepted beat
    always @(posedge aclk) begin : driver
        reading_t           r;
        bit                 got;
        logic               next_valid;
        logic [COUNT_W-1:0] next_count;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            fresh_valid <= 1'b0;
        end else begin
            got        = 1'b0;
            r          = '0;
            next_valid = s_valid;
            next_count = s_edge_count;
            if (s_valid && s_ready) begin
                got        = predict_reading(s_edge_count, r);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_counts.size() != 0 &&
                $urandom_range(99) >= send_gap_pct) begin
                next_valid = 1'b1;
                next_count = pending_counts.pop_front();
            end
            s_valid       <= next_valid;
            s_edge_count  <= next_count;
            fresh_valid   <= got;
            fresh_reading <= r;
        end
    end

    // monitor: queue last beat's prediction, compare each result beat with the oldest
    always @(posedge aclk) begin : monitor
        reading_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (fresh_valid)
                expected_readings.push_back(fresh_reading);
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with nothing expected, actual freq %0d cap %0d",
                                 $time, m_freq_hz, m_cap_value);
                end else begin
                    want = expected_readings.pop_front();
                    check_field("freq_hz", 64'(want.freq_hz), 64'(m_freq_hz));
                    check_field("cap_value", 64'(want.cap_value), 64'(m_cap_value));
                    check_field("unit_code", 64'(want.unit), 64'(m_unit_code));
                    check_field("next_gate_ms", 64'(want.next_gate), 64'(m_next_gate_ms));
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [cmf_pkg::CAP_W-1:0] constants [5];
        int                        gap_pcts [5];
        int                        stall_pcts [5];
        constants  = '{OSC_CONST_MAX, '0, cmf_pkg::CAP_W'($urandom), 26'd1, OSC_CONST_DEFAULT};
        gap_pcts   = '{0, 52, 0, 35, 0};
        stall_pcts = '{0, 0, 52, 35, 0};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset constant: gate steps, zero hertz, exact one hertz,
        // partly filled history, full-scale and alternating bit patterns
        @(negedge aclk);
        pending_counts = '{24'd0, 24'd1, 24'd1, 24'd2, 24'd3, 24'd14, 24'd15, 24'd14,
                           24'd15, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'd1, 24'd0,
                           24'd3, 24'd3000, 24'd300000, 24'd30, 24'd1, 24'd4,
                           24'h800000, 24'd7};
        wait_quiet();

        // random phases, each under its own constant and idling pattern
        for (int p = 0; p < 5; p++) begin
            write_constant(constants[p]);
            @(negedge aclk);
            send_gap_pct = gap_pcts[p];
            stall_pct    = stall_pcts[p];
            load_random(PHASE_ITEMS);
            wait_quiet();
        end

        @(negedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/cmf_pkg.sv
design/cmf_div.sv
design/cmf_ring.sv
design/capacitance_meter_from_frequency.sv
test/capacitance_meter_from_frequency_test.sv
